FILE: design/pns_pkg.sv
// shared types, constants and helpers for the pink noise shaper
package pns_pkg;

    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_FILTER_ORDER = 3;

    localparam int DATA_W   = 32;   // q12.20 state word
    localparam int Q_FRAC   = 20;
    localparam int COEF_W   = 24;   // q4.20 coefficient, also widest multiplier operand
    localparam int GAIN_W   = 16;
    localparam int NUM_COEF = 3;
    localparam int TAP_W    = 2;
    localparam int ACC_W    = 58;   // three 56 bit products plus the seeded term
    localparam int CNT_W    = 5;    // holds COEF_W
    localparam int REG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FB_LD,
        S_FB_RUN,
        S_FF_LD,
        S_FF_RUN,
        S_MOD_LD,
        S_MOD_RUN,
        S_GAIN_LD,
        S_GAIN_RUN,
        S_OUT
    } t_state;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NOISE_MODE  = 3'd0,
        REG_VOLUME_GAIN = 3'd1,
        REG_FB_COEF_1   = 3'd2,
        REG_FB_COEF_2   = 3'd3,
        REG_FB_COEF_3   = 3'd4,
        REG_FF_COEF_1   = 3'd5,
        REG_FF_COEF_2   = 3'd6,
        REG_FF_COEF_3   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic             clr;    // load accumulator with seed
        logic             load;   // load operands and start a product
        logic             neg;    // subtract the product
        logic             sgn;    // multiplier is two's complement
        logic [CNT_W-1:0] nbits;  // multiplier bits to consume
    } t_mac_ctl;

    // q12.20 word at 40 fraction bits plus half an lsb, for round half up
    function automatic logic [ACC_W-1:0] q20_seed(input logic [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W-Q_FRAC){v[DATA_W-1]}}, v, 1'b1, {(Q_FRAC-1){1'b0}}};
    endfunction

    // drop 20 fraction bits and saturate to a 32 bit word
    function automatic logic [DATA_W-1:0] sat_q20(input logic [ACC_W-1:0] acc);
        logic [ACC_W-Q_FRAC-DATA_W:0] hi;
        logic [DATA_W-1:0]            res;
        hi = acc[ACC_W-1:Q_FRAC+DATA_W-1];
        if ((&hi) || !(|hi)) begin
            res = acc[Q_FRAC +: DATA_W];
        end else if (acc[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: design/pns_serial_mac.sv
// bit-serial shift-add multiplier with a shared accumulator
module pns_serial_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pns_pkg::t_mac_ctl             i_ctl,
    input  logic [pns_pkg::ACC_W-1:0]     i_init,
    input  logic [pns_pkg::DATA_W-1:0]    i_mcand,
    input  logic [pns_pkg::COEF_W-1:0]    i_mplier,
    output logic                          o_busy,
    output logic [pns_pkg::ACC_W-1:0]     o_acc
);
    import pns_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_mcand;
    logic [COEF_W-1:0] r_mplier;
    logic              r_neg;
    logic              r_sgn;
    logic              do_sub;
    logic [ACC_W-1:0]  n_acc;

    // the sign bit of a two's complement multiplier carries negative weight
    assign do_sub = r_neg ^ (r_sgn && (r_cnt == CNT_W'(1)));
    assign n_acc  = r_acc + (r_mcand ^ {ACC_W{do_sub}}) + ACC_W'(do_sub);
    assign o_busy = (r_cnt != '0);
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= i_ctl.nbits;
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= i_init;
        end else if (o_busy && r_mplier[0]) begin
            r_acc <= n_acc;
        end
        if (i_ctl.load) begin
            r_mcand  <= {{(ACC_W-DATA_W){i_mcand[DATA_W-1]}}, i_mcand};
            r_mplier <= i_mplier;
            r_neg    <= i_ctl.neg;
            r_sgn    <= i_ctl.sgn;
        end else if (o_busy) begin
            r_mcand  <= {r_mcand[ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[COEF_W-1:1]};
        end
    end

endmodule

FILE: design/pns_delay.sv
// filter delay line, shifts in the new state word at its head
module pns_delay #(
    parameter int FILTER_ORDER = pns_pkg::DEF_FILTER_ORDER
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [pns_pkg::DATA_W-1:0] i_din,
    output logic [pns_pkg::DATA_W-1:0] o_taps [pns_pkg::NUM_COEF]
);
    import pns_pkg::*;

    logic [DATA_W-1:0] r_d [FILTER_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FILTER_ORDER; k++) begin
                r_d[k] <= '0;
            end
        end else if (i_shift) begin
            r_d[0] <= i_din;
            for (int k = 1; k < FILTER_ORDER; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    // taps past the filter order read as zero, words past three taps only shift
    for (genvar g = 0; g < NUM_COEF; g++) begin : g_tap
        if (g < FILTER_ORDER) begin : g_on
            assign o_taps[g] = r_d[g];
        end else begin : g_off
            assign o_taps[g] = '0;
        end
    end

endmodule

FILE: design/pink_noise_shaper_with_gain.sv
// top level: third order iir pink noise shaper with volume modulation and gain
//
//  channel   direction  tdata / index            tuser  tlast
//  s_axis    in         noise_sample, volume_mod  -      -
//  m_axis    out        out_sample                -      -
//  cfg       in         index 0..7, data 24 bits  -      -
//
//  one bit-serial multiplier consumes one multiplier bit per cycle for
//  every product: volume and gain in white mode, and the feedback and
//  feedforward products before them in pink mode.
//  reset is synchronous and clears the delay line, state and config registers.
//  a new item is taken while a finished result waits in the output register;
//  a stalled result only holds the last step until the register frees.
module pink_noise_shaper_with_gain #(
    parameter int SAMPLE_BITS  = pns_pkg::DEF_SAMPLE_BITS,
    parameter int FILTER_ORDER = pns_pkg::DEF_FILTER_ORDER
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // noise_sample, volume_mod
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // out_sample
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [pns_pkg::REG_IDX_W-1:0]        i_cfg_addr,
    input  logic [pns_pkg::COEF_W-1:0]           i_cfg_wdata
);
    import pns_pkg::*;

    localparam int OUT_W  = ((SAMPLE_BITS+7)/8)*8;
    localparam int FRAC_S = SAMPLE_BITS - 1;
    localparam int NTAP   = (FILTER_ORDER < NUM_COEF) ? FILTER_ORDER : NUM_COEF;
    // sample to q12.20
    localparam int X_UP   = (FRAC_S < Q_FRAC) ? Q_FRAC - FRAC_S : 0;
    localparam int X_DN   = (FRAC_S > Q_FRAC) ? FRAC_S - Q_FRAC : 0;
    localparam int X_RSH  = (X_DN > 0) ? X_DN - 1 : 0;
    localparam logic signed [DATA_W-1:0] X_RND =
        (X_DN > 0) ? (DATA_W'(1) << X_RSH) : '0;
    // q12.20 to sample
    localparam int O_W    = DATA_W + 4;
    localparam int O_DN   = X_UP;
    localparam int O_UP   = X_DN;
    localparam int O_RSH  = (O_DN > 0) ? O_DN - 1 : 0;
    localparam logic signed [O_W-1:0] O_RND = (O_DN > 0) ? (O_W'(1) << O_RSH) : '0;
    localparam logic signed [O_W-1:0] S_MAX = (O_W'(1) << FRAC_S) - O_W'(1);
    localparam logic signed [O_W-1:0] S_MIN = -S_MAX - O_W'(1);

    t_state                  r_state, n_state;
    logic                    r_mode;
    logic [GAIN_W-1:0]       r_gain;
    logic [COEF_W-1:0]       r_fb [NUM_COEF];
    logic [COEF_W-1:0]       r_ff [NUM_COEF];
    logic [SAMPLE_BITS-1:0]  r_m;
    logic [DATA_W-1:0]       r_w;
    logic [DATA_W-1:0]       r_y, n_y;
    logic [TAP_W-1:0]        r_tap;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_data;

    logic                    accept;
    logic                    last_tap;
    logic [SAMPLE_BITS-1:0]  in_x, in_mod;
    logic signed [DATA_W-1:0] x_ext, x_q;
    logic signed [O_W-1:0]   o_ext, o_scaled;
    logic [SAMPLE_BITS-1:0]  o_sample;
    logic [DATA_W-1:0]       taps [NUM_COEF];
    logic [DATA_W-1:0]       d_sel;
    logic [COEF_W-1:0]       fb_sel, ff_sel;
    logic [ACC_W-1:0]        seed_mod, seed_gain;

    t_mac_ctl                mac_ctl;
    logic [ACC_W-1:0]        mac_init;
    logic [DATA_W-1:0]       mac_mcand;
    logic [COEF_W-1:0]       mac_mplier;
    logic                    mac_busy;
    logic [ACC_W-1:0]        mac_acc;
    logic                    w_load, y_load, delay_shift, out_load, tap_inc, tap_clr;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign last_tap        = (r_tap == TAP_W'(NTAP - 1));
    assign in_x            = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_mod          = i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign seed_mod        = ACC_W'(1) << (SAMPLE_BITS - 1);
    assign seed_gain       = ACC_W'(1) << (GAIN_W - 1);

    assign x_ext = {{(DATA_W-SAMPLE_BITS){in_x[SAMPLE_BITS-1]}}, in_x};
    assign x_q   = ((x_ext + X_RND) >>> X_DN) <<< X_UP;

    // round half up to the sample grid, then clamp
    assign o_ext    = {{(O_W-DATA_W){r_y[DATA_W-1]}}, r_y};
    assign o_scaled = ((o_ext + O_RND) >>> O_DN) <<< O_UP;
    always_comb begin
        if (o_scaled > S_MAX) begin
            o_sample = S_MAX[SAMPLE_BITS-1:0];
        end else if (o_scaled < S_MIN) begin
            o_sample = S_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_sample = o_scaled[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        case (r_tap)
            TAP_W'(0): begin
                d_sel  = taps[0];
                fb_sel = r_fb[0];
                ff_sel = r_ff[0];
            end
            TAP_W'(1): begin
                d_sel  = taps[1];
                fb_sel = r_fb[1];
                ff_sel = r_ff[1];
            end
            default: begin
                d_sel  = taps[2];
                fb_sel = r_fb[2];
                ff_sel = r_ff[2];
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (accept) n_state = r_mode ? S_FB_LD : S_MOD_LD;
            S_FB_LD:    n_state = S_FB_RUN;
            S_FB_RUN:   if (!mac_busy) n_state = last_tap ? S_FF_LD : S_FB_LD;
            S_FF_LD:    n_state = S_FF_RUN;
            S_FF_RUN:   if (!mac_busy) n_state = last_tap ? S_MOD_LD : S_FF_LD;
            S_MOD_LD:   n_state = S_MOD_RUN;
            S_MOD_RUN:  if (!mac_busy) n_state = S_GAIN_LD;
            S_GAIN_LD:  n_state = S_GAIN_RUN;
            S_GAIN_RUN: if (!mac_busy) n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        mac_ctl     = '0;
        mac_init    = seed_mod;
        mac_mcand   = r_y;
        mac_mplier  = COEF_W'(r_m);
        n_y         = r_y;
        w_load      = 1'b0;
        y_load      = 1'b0;
        delay_shift = 1'b0;
        out_load    = 1'b0;
        tap_inc     = 1'b0;
        tap_clr     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    mac_ctl.clr = 1'b1;
                    tap_clr     = 1'b1;
                    if (r_mode) begin
                        mac_init = q20_seed(x_q);
                    end else begin
                        y_load = 1'b1;
                        n_y    = x_q;
                    end
                end
            end
            S_FB_LD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.neg   = 1'b1;
                mac_ctl.sgn   = 1'b1;
                mac_ctl.nbits = CNT_W'(COEF_W);
                mac_mcand     = d_sel;
                mac_mplier    = fb_sel;
            end
            S_FB_RUN: begin
                if (!mac_busy) begin
                    if (last_tap) begin
                        w_load      = 1'b1;
                        mac_ctl.clr = 1'b1;
                        mac_init    = q20_seed(sat_q20(mac_acc));
                        tap_clr     = 1'b1;
                    end else begin
                        tap_inc = 1'b1;
                    end
                end
            end
            S_FF_LD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.sgn   = 1'b1;
                mac_ctl.nbits = CNT_W'(COEF_W);
                mac_mcand     = d_sel;
                mac_mplier    = ff_sel;
            end
            S_FF_RUN: begin
                if (!mac_busy) begin
                    if (last_tap) begin
                        y_load      = 1'b1;
                        n_y         = sat_q20(mac_acc);
                        delay_shift = 1'b1;
                        mac_ctl.clr = 1'b1;
                    end else begin
                        tap_inc = 1'b1;
                    end
                end
            end
            S_MOD_LD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.nbits = CNT_W'(SAMPLE_BITS);
            end
            S_MOD_RUN: begin
                if (!mac_busy) begin
                    y_load      = 1'b1;
                    n_y         = mac_acc[SAMPLE_BITS +: DATA_W];
                    mac_ctl.clr = 1'b1;
                    mac_init    = seed_gain;
                end
            end
            S_GAIN_LD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.nbits = CNT_W'(GAIN_W);
                mac_mplier    = COEF_W'(r_gain);
            end
            S_GAIN_RUN: begin
                if (!mac_busy) begin
                    y_load = 1'b1;
                    n_y    = mac_acc[GAIN_W +: DATA_W];
                end
            end
            S_OUT: begin
                out_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (tap_clr) begin
                r_tap <= '0;
            end else if (tap_inc) begin
                r_tap <= r_tap + TAP_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m <= {~in_mod[SAMPLE_BITS-1], in_mod[SAMPLE_BITS-2:0]};
        end
        if (w_load) begin
            r_w <= sat_q20(mac_acc);
        end
        if (y_load) begin
            r_y <= n_y;
        end
        if (out_load) begin
            r_out_data <= o_sample;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_gain <= GAIN_RESET;
            for (int k = 0; k < NUM_COEF; k++) begin
                r_fb[k] <= '0;
                r_ff[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_NOISE_MODE:  r_mode  <= i_cfg_wdata[0];
                REG_VOLUME_GAIN: r_gain  <= i_cfg_wdata[GAIN_W-1:0];
                REG_FB_COEF_1:   r_fb[0] <= i_cfg_wdata;
                REG_FB_COEF_2:   r_fb[1] <= i_cfg_wdata;
                REG_FB_COEF_3:   r_fb[2] <= i_cfg_wdata;
                REG_FF_COEF_1:   r_ff[0] <= i_cfg_wdata;
                REG_FF_COEF_2:   r_ff[1] <= i_cfg_wdata;
                REG_FF_COEF_3:   r_ff[2] <= i_cfg_wdata;
                default:         r_mode  <= r_mode;
            endcase
        end
    end

    pns_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_init   (mac_init),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .o_busy   (mac_busy),
        .o_acc    (mac_acc)
    );

    pns_delay #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (delay_shift),
        .i_din   (r_w),
        .o_taps  (taps)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

endmodule

FILE: design/pns_checker.sv
// port-level checks for the pink noise shaper, bound to the top level
module pns_checker #(
    parameter int SAMPLE_BITS = pns_pkg::DEF_SAMPLE_BITS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    // out_sample
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]   o_m_axis_tdata
);

    // a waiting result keeps its value until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: after a transfer in the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again right after a transfer");

    // an idle block stays ready until an item arrives
    a_idle_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready && !i_s_axis_tvalid |=> o_s_axis_tready)
        else $error("ready dropped with no input transfer");

    // a new result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind pink_noise_shaper_with_gain pns_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pns_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
